// ===== design/pphm_pkg.sv =====
// Package for the primer pair Hamming matcher.
// Holds command codes, register indexes, sizes and the item types shared by the front and back parts.
// Depends on nothing.
package pphm_pkg;

    localparam int NUM_PAIRS = 16;
    localparam int MAX_PRIMER_LEN = 32;
    localparam int PAIR_W = 4;
    localparam int POS_W = 5;

    localparam logic [1:0] CMD_READ = 2'd0;
    localparam logic [1:0] CMD_LOAD_BASE = 2'd1;
    localparam logic [1:0] CMD_LOAD_LEN = 2'd2;

    localparam logic [1:0] KIND_READ = 2'd0;
    localparam logic [1:0] KIND_BASE = 2'd1;
    localparam logic [1:0] KIND_LEN = 2'd2;

    localparam logic REG_MAX_MM = 1'b0;
    localparam logic REG_PAIRS_IN_USE = 1'b1;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] read1_base;
        logic [7:0] read2_base;
        logic       read1_present;
        logic       read2_present;
        logic       last_position;
        logic [3:0] pair_slot;
        logic       primer_side;
        logic [4:0] base_position;
        logic [7:0] primer_base;
        logic [5:0] primer_length;
    } job_t;

    localparam int JOB_W = $bits(job_t);

endpackage

// ===== design/pphm_front.sv =====
// Front part: accepts input items, drops unknown commands, and queues jobs.
// Depends on pphm_pkg.
module pphm_front #(
    parameter int DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  pphm_pkg::job_t     in_job,
    input  logic               in_keep,
    output logic               q_valid,
    input  logic               q_pop,
    output pphm_pkg::job_t     q_job
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    pphm_pkg::job_t mem [DEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   cnt_reg;
    logic          push, pop;

    assign in_ready = (cnt_reg != (AW+1)'(DEPTH));
    assign push = in_valid && in_ready && in_keep;
    assign pop = q_pop && q_valid;
    assign q_valid = (cnt_reg != '0);
    assign q_job = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= in_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule

// ===== design/pphm_back.sv =====
// Back part: primer table, per-pair mismatch sweep and end-of-read search.
// Depends on pphm_pkg.
module pphm_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    output logic           job_pop,
    input  pphm_pkg::job_t job,
    input  logic [6:0]     max_mismatches,
    input  logic [4:0]     pairs_in_use,
    output logic           res_valid,
    input  logic           res_ready,
    output logic [119:0]   res_data
);
    localparam int PW = pphm_pkg::PAIR_W;
    localparam int LW = pphm_pkg::POS_W;
    localparam int NP = pphm_pkg::NUM_PAIRS;
    localparam int ML = pphm_pkg::MAX_PRIMER_LEN;

    typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_SEARCH, S_OUT} state_t;

    logic [7:0] chars0 [NP*ML];
    logic [7:0] chars1 [NP*ML];
    logic [5:0] lens [NP*2];
    logic [6:0] mm_reg [NP];
    logic [31:0] hits_reg [NP];

    state_t state_reg;
    pphm_pkg::job_t job_reg;
    logic [PW:0] p_reg;
    logic [5:0] cnt_reg, len1_reg, len2_reg;
    logic [31:0] unm_reg, tot_reg;
    logic [119:0] res_reg;
    logic [7:0] rd0_reg, rd1_reg;

    logic [PW-1:0] p_idx, prev_idx;
    logic hit0, hit1, found;
    logic [7:0] mm_sum;
    logic [6:0] mm_new;
    logic [PW:0] limit;

    assign p_idx = p_reg[PW-1:0];
    assign prev_idx = PW'(p_reg - 1'b1);
    assign hit0 = job_reg.read1_present && (cnt_reg < lens[{prev_idx, 1'b0}])
        && (rd0_reg != job_reg.read1_base);
    assign hit1 = job_reg.read2_present && (cnt_reg < lens[{prev_idx, 1'b1}])
        && (rd1_reg != job_reg.read2_base);
    assign mm_sum = {1'b0, mm_reg[prev_idx]} + {7'd0, hit0} + {7'd0, hit1};
    assign mm_new = (mm_sum > 8'd127) ? 7'd127 : mm_sum[6:0];
    assign found = (len1_reg >= lens[{p_idx, 1'b0}]) && (len2_reg >= lens[{p_idx, 1'b1}])
        && (mm_reg[p_idx] <= max_mismatches);
    assign limit = (pairs_in_use > (PW+1)'(NP)) ? (PW+1)'(NP) : pairs_in_use;
    assign job_pop = (state_reg == S_IDLE) && job_valid;
    assign res_valid = (state_reg == S_OUT);
    assign res_data = res_reg;

    always_ff @(posedge clk)
    begin
        if (job_pop && job.kind == pphm_pkg::KIND_BASE)
        begin
            if (job.primer_side)
            begin
                chars1[{job.pair_slot, job.base_position}] <= job.primer_base;
            end
            else
            begin
                chars0[{job.pair_slot, job.base_position}] <= job.primer_base;
            end
        end
        if (job_pop && job.kind == pphm_pkg::KIND_LEN)
        begin
            lens[{job.pair_slot, job.primer_side}] <=
                (job.primer_length > 6'(ML)) ? 6'(ML) : job.primer_length;
        end
        rd0_reg <= chars0[{p_idx, cnt_reg[LW-1:0]}];
        rd1_reg <= chars1[{p_idx, cnt_reg[LW-1:0]}];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            job_reg <= '0;
            p_reg <= '0;
            cnt_reg <= '0;
            len1_reg <= '0;
            len2_reg <= '0;
            unm_reg <= '0;
            tot_reg <= '0;
            res_reg <= '0;
            for (int i = 0; i < NP; i++)
            begin
                mm_reg[i] <= '0;
                hits_reg[i] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (job_pop && job.kind == pphm_pkg::KIND_READ)
                    begin
                        job_reg <= job;
                        p_reg <= '0;
                        state_reg <= S_SWEEP;
                    end
                end
                S_SWEEP:
                begin
                    if (p_reg != '0)
                    begin
                        mm_reg[prev_idx] <= mm_new;
                    end
                    if (p_reg == (PW+1)'(NP))
                    begin
                        p_reg <= '0;
                        if (job_reg.read1_present && len1_reg < 6'(ML))
                        begin
                            len1_reg <= len1_reg + 6'd1;
                        end
                        if (job_reg.read2_present && len2_reg < 6'(ML))
                        begin
                            len2_reg <= len2_reg + 6'd1;
                        end
                        if (cnt_reg < 6'(ML))
                        begin
                            cnt_reg <= cnt_reg + 6'd1;
                        end
                        state_reg <= job_reg.last_position ? S_SEARCH : S_IDLE;
                    end
                    else
                    begin
                        p_reg <= p_reg + 1'b1;
                    end
                end
                S_SEARCH:
                begin
                    if (p_reg >= limit)
                    begin
                        res_reg <= {7'd0, tot_reg + 32'd1, unm_reg + 32'd1, 32'd0,
                                    6'd0, 6'd0, 4'd0, 1'b0};
                        unm_reg <= unm_reg + 32'd1;
                        tot_reg <= tot_reg + 32'd1;
                        for (int i = 0; i < NP; i++)
                        begin
                            mm_reg[i] <= '0;
                        end
                        cnt_reg <= '0;
                        len1_reg <= '0;
                        len2_reg <= '0;
                        p_reg <= '0;
                        state_reg <= S_OUT;
                    end
                    else if (found)
                    begin
                        hits_reg[p_idx] <= hits_reg[p_idx] + 32'd1;
                        res_reg <= {7'd0, tot_reg + 32'd1, unm_reg, hits_reg[p_idx] + 32'd1,
                                    lens[{p_idx, 1'b1}], lens[{p_idx, 1'b0}], p_idx, 1'b1};
                        tot_reg <= tot_reg + 32'd1;
                        for (int i = 0; i < NP; i++)
                        begin
                            mm_reg[i] <= '0;
                        end
                        cnt_reg <= '0;
                        len1_reg <= '0;
                        len2_reg <= '0;
                        p_reg <= '0;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        p_reg <= p_reg + 1'b1;
                    end
                end
                S_OUT:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// ===== design/primer_pair_hamming_matcher.sv =====
// Top level of the primer pair Hamming matcher.
// Instantiates pphm_front and pphm_back; depends on pphm_pkg.
//
// The command travels in tuser. A load command is written into the primer table when the back
// part takes it from the queue. A read-pair base position is popped, then every table pair is
// swept to read both primer bases; the table read is registered. The transfer that carries
// tlast then adds a search over the pairs in order, stopping at the first pair that matches,
// or after min(pairs_in_use, 16) pairs when none does, and the result is held until it is
// taken. A four-entry job queue lets input transfers continue while the back part is busy.
module primer_pair_hamming_matcher (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // read1_base, read2_base, read1_present, read2_present, pair_slot,
    // primer_side, base_position, primer_base, primer_length, zero pad
    input  logic [47:0]  s_axis_tdata,
    // cmd
    input  logic [1:0]   s_axis_tuser,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // matched, matched_slot, trim_read1, trim_read2, slot_hits, unmatched_total,
    // pairs_total, zero pad
    output logic [119:0] m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [6:0]   cfg_data
);
    logic [6:0] mm_reg;
    logic [4:0] piu_reg;
    pphm_pkg::job_t in_job, q_job;
    logic keep, q_valid, q_pop;

    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mm_reg <= '0;
            piu_reg <= 5'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                pphm_pkg::REG_MAX_MM:
                begin
                    mm_reg <= cfg_data;
                end
                pphm_pkg::REG_PAIRS_IN_USE:
                begin
                    piu_reg <= cfg_data[4:0];
                end
                default:
                begin
                    mm_reg <= mm_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        in_job.kind = s_axis_tuser;
        in_job.read1_base = s_axis_tdata[7:0];
        in_job.read2_base = s_axis_tdata[15:8];
        in_job.read1_present = s_axis_tdata[16];
        in_job.read2_present = s_axis_tdata[17];
        in_job.last_position = s_axis_tlast;
        in_job.pair_slot = s_axis_tdata[21:18];
        in_job.primer_side = s_axis_tdata[22];
        in_job.base_position = s_axis_tdata[27:23];
        in_job.primer_base = s_axis_tdata[35:28];
        in_job.primer_length = s_axis_tdata[41:36];
        keep = (s_axis_tuser == pphm_pkg::CMD_READ)
            || (s_axis_tuser == pphm_pkg::CMD_LOAD_BASE)
            || (s_axis_tuser == pphm_pkg::CMD_LOAD_LEN);
    end

    pphm_front #(.DEPTH(4)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_job(in_job), .in_keep(keep),
        .q_valid(q_valid), .q_pop(q_pop), .q_job(q_job)
    );

    pphm_back u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(q_valid), .job_pop(q_pop), .job(q_job),
        .max_mismatches(mm_reg), .pairs_in_use(piu_reg),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res_data(m_axis_tdata)
    );
endmodule
